// ===== src/scwm_pkg.sv =====
// Shared constants, types and control structures of the stereo correlation and width meter.
`timescale 1ns / 1ps

package scwm_pkg;

    // Length cap: at most 2**MAX_SAMPLES_LOG2 pairs are accumulated per block.
    localparam int unsigned MAX_SAMPLES_LOG2 = 25;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PROD_W   = 2 * SAMPLE_W;
    localparam int unsigned CNT_W    = MAX_SAMPLES_LOG2 + 1;

    // Square sums never exceed 2**(30 + MAX_SAMPLES_LOG2); the cross sum is signed.
    localparam int unsigned SUM_SQ_W = PROD_W - 1 + MAX_SAMPLES_LOG2;
    localparam int unsigned SUM_X_W  = PROD_W + MAX_SAMPLES_LOG2;
    localparam int unsigned MS_W     = SUM_SQ_W + 2;

    // Shared add/subtract unit width: holds the product of two square sums.
    localparam int unsigned DP_W     = 2 * SUM_SQ_W;

    localparam int unsigned QUO_W    = 32;
    localparam int unsigned ROOT_W   = QUO_W / 2;
    localparam int unsigned STEP_W   = $clog2(SUM_SQ_W);

    localparam logic [CNT_W-1:0] SAMPLE_CAP = CNT_W'(1) << MAX_SAMPLES_LOG2;

    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(SUM_SQ_W - 1);
    localparam logic [STEP_W-1:0] CDIV_LAST = STEP_W'(QUO_W - 2);
    localparam logic [STEP_W-1:0] WDIV_LAST = STEP_W'(QUO_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

    localparam int unsigned WIDTH_SCALE_LOG2 = 16;

    localparam logic signed [15:0] CORR_MAX  = 16'sh7FFF;
    localparam logic [15:0]        WIDTH_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        MUL_LL,
        MUL_RR,
        MUL_LR
    } t_mul_sel;

    typedef enum logic [1:0] {
        ADD_NONE,
        ADD_LL,
        ADD_RR,
        ADD_LR
    } t_add_sel;

    typedef struct packed {
        logic     capture;
        logic     clear;
        t_mul_sel mul_sel;
        t_add_sel add_sel;
    } t_acc_ctrl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LL,
        ST_ACC_LL,
        ST_ACC_RR,
        ST_ACC_LR,
        ST_MID_BASE,
        ST_MID,
        ST_SIDE,
        ST_MAG,
        ST_MAG_SQ,
        ST_DEN,
        ST_DIV,
        ST_SQRT,
        ST_WIDTH_CHK,
        ST_OUT
    } t_state;

endpackage

// ===== src/stereo_correlation_width_meter.sv =====
// Top level of the stereo correlation and width meter: sequencer and shared wide add/subtract unit.
`timescale 1ns / 1ps

// Usage. Left/right sample pairs arrive on the input channel (i_valid, o_stall); a
// transaction is accepted at a rising edge with i_valid high and o_stall low. After
// the accepting state each pair passes through MUL_LL, ACC_LL, ACC_RR and ACC_LR, in
// which one 16x16 multiplier forms L*L, R*R and L*R in turn and adds them to the sums;
// o_stall stays high until the pair is added, so the next pair waits. Mid and side
// energies are derived from those sums as L2+R2+2LR and L2+R2-2LR.
// A pair marked last starts the final computation on one shared wide add/subtract unit:
// for the correlation, the mid and side sums, the magnitude, the magnitude square and
// the denominator product by shift-and-add, a 31-step restoring divide and a 16-step
// square root; for the width, a range check, a 32-step divide and a 16-step root; then
// the load of the output register. A silent channel skips the correlation steps and
// zero mid energy skips the width steps. The result transaction carries
// o_phase_correlation and o_stereo_width, and the sums clear.
// The result sits in an output register, so new pairs are accepted while it waits. If
// the receiver keeps i_stall high until the next block finishes, the sequencer holds
// its result and keeps o_stall high until the output register frees up.
// Reset (synchronous, active low) clears the sums, the count and any pending result and
// sets stereo_mode (APB byte address 0) to 1; at 0 the right sample is replaced by the left.

module stereo_correlation_width_meter import scwm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Sample pair channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [15:0]  i_left_sample,
    input  logic signed [15:0]  i_right_sample,
    input  logic                i_last_sample,
    // Result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_phase_correlation,
    output logic [15:0]         o_stereo_width,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic REG_IDX_STEREO_MODE = 1'b0;

    // Control state
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   r_stereo_mode;

    // Working registers of the final computation
    logic                       r_last;
    logic [DP_W-1:0]            r_rem;
    logic [DP_W-1:0]            r_div;
    logic [DP_W-1:0]            r_num;
    logic [SUM_SQ_W-1:0]        r_mplr;
    logic [QUO_W-1:0]           r_quo;
    logic [ROOT_W-1:0]          r_root;
    logic [STEP_W-1:0]          r_cnt;
    logic                       r_wpass;
    logic                       r_neg;
    logic [MS_W-1:0]            r_mid;
    logic [MS_W-1:0]            r_side;
    logic signed [15:0]         r_corr;
    logic [15:0]                r_width;
    logic signed [15:0]         r_out_corr;
    logic [15:0]                r_out_width;

    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_cfg_write;
    logic signed [SAMPLE_W-1:0] w_right;
    t_acc_ctrl                  w_acc_ctrl;
    logic [SUM_SQ_W-1:0]        w_sum_ll;
    logic [SUM_SQ_W-1:0]        w_sum_rr;
    logic signed [SUM_X_W-1:0]  w_sum_lr;
    logic [DP_W-1:0]            w_lr_ext;
    logic [DP_W-1:0]            w_lr2;
    logic                       w_lr_neg;
    logic                       w_silent;
    logic                       w_mid_zero;
    logic [DP_W-1:0]            w_rem_dbl;
    logic [DP_W-1:0]            w_rem_quad;
    logic [DP_W-1:0]            w_trial;
    logic [ROOT_W-1:0]          w_root_next;
    logic signed [15:0]         w_corr_val;
    logic                       w_mul_last;
    logic                       w_div_last;
    logic                       w_sqrt_last;

    // Shared add/subtract unit
    logic [DP_W-1:0]            w_add_a;
    logic [DP_W-1:0]            w_add_b;
    logic                       w_add_sub;
    logic [DP_W:0]              w_add_full;
    logic [DP_W-1:0]            w_add_y;
    logic                       w_add_c;

    // ---------------------------------------------------------------------
    // Configuration port. Writes are zero-wait; reads are combinational.
    // ---------------------------------------------------------------------
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[2] == REG_IDX_STEREO_MODE) begin
            prdata = {31'b0, r_stereo_mode};
        end else begin
            prdata = '0;
        end
    end

    // ---------------------------------------------------------------------
    // Sample accumulation. In mono mode the left sample feeds both channels.
    // ---------------------------------------------------------------------
    assign w_accept = i_valid && !o_stall;
    assign w_right  = r_stereo_mode ? i_right_sample : i_left_sample;

    scwm_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_acc_ctrl),
        .i_left   (i_left_sample),
        .i_right  (w_right),
        .o_sum_ll (w_sum_ll),
        .o_sum_rr (w_sum_rr),
        .o_sum_lr (w_sum_lr)
    );

    // ---------------------------------------------------------------------
    // Helper terms for the final computation.
    // ---------------------------------------------------------------------
    assign w_lr_ext   = DP_W'(w_sum_lr);
    assign w_lr2      = {w_lr_ext[DP_W-2:0], 1'b0};
    assign w_lr_neg   = w_sum_lr[SUM_X_W-1];
    assign w_silent   = (w_sum_ll == '0) || (w_sum_rr == '0);
    assign w_mid_zero = (r_mid == '0);

    assign w_rem_dbl  = {r_rem[DP_W-2:0], 1'b0};
    assign w_rem_quad = {r_rem[DP_W-3:0], r_quo[QUO_W-1:QUO_W-2]};
    assign w_trial    = DP_W'({r_root, 2'b01});

    assign w_add_full = {1'b0, w_add_a} + {1'b0, w_add_b ^ {DP_W{w_add_sub}}}
                      + (DP_W + 1)'(w_add_sub);
    assign w_add_y    = w_add_full[DP_W-1:0];
    assign w_add_c    = w_add_full[DP_W];

    assign w_root_next = {r_root[ROOT_W-2:0], w_add_c};

    // A root above 32767 only happens at full positive correlation and is clamped;
    // a negative root of 32768 maps exactly onto -1.
    always_comb begin
        if (r_neg) begin
            w_corr_val = -$signed(w_root_next);
        end else if (w_root_next[ROOT_W-1]) begin
            w_corr_val = CORR_MAX;
        end else begin
            w_corr_val = $signed(w_root_next);
        end
    end

    assign w_mul_last  = (r_cnt == MUL_LAST);
    assign w_div_last  = (r_cnt == (r_wpass ? WDIV_LAST : CDIV_LAST));
    assign w_sqrt_last = (r_cnt == SQRT_LAST);
    assign w_out_free  = !r_out_valid || !i_stall;

    // ---------------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MUL_LL;
                end
            end
            ST_MUL_LL: n_state = ST_ACC_LL;
            ST_ACC_LL: n_state = ST_ACC_RR;
            ST_ACC_RR: n_state = ST_ACC_LR;
            ST_ACC_LR: n_state = r_last ? ST_MID_BASE : ST_IDLE;
            ST_MID_BASE: n_state = ST_MID;
            ST_MID: n_state = ST_SIDE;
            ST_SIDE: n_state = w_silent ? ST_WIDTH_CHK : ST_MAG;
            ST_MAG: n_state = ST_MAG_SQ;
            ST_MAG_SQ: begin
                if (w_mul_last) begin
                    n_state = ST_DEN;
                end
            end
            ST_DEN: begin
                if (w_mul_last) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_last) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (w_sqrt_last) begin
                    n_state = r_wpass ? ST_OUT : ST_WIDTH_CHK;
                end
            end
            ST_WIDTH_CHK: begin
                if (w_mid_zero || w_add_c) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: outputs (accumulator control and shared unit operands).
    // ---------------------------------------------------------------------
    always_comb begin
        o_stall    = 1'b1;
        w_acc_ctrl = '{capture: 1'b0, clear: 1'b0, mul_sel: MUL_LL, add_sel: ADD_NONE};
        w_add_a    = '0;
        w_add_b    = '0;
        w_add_sub  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall            = 1'b0;
                w_acc_ctrl.capture = w_accept;
            end
            ST_MUL_LL: begin
                w_acc_ctrl.mul_sel = MUL_LL;
            end
            ST_ACC_LL: begin
                w_acc_ctrl.add_sel = ADD_LL;
                w_acc_ctrl.mul_sel = MUL_RR;
            end
            ST_ACC_RR: begin
                w_acc_ctrl.add_sel = ADD_RR;
                w_acc_ctrl.mul_sel = MUL_LR;
            end
            ST_ACC_LR: begin
                w_acc_ctrl.add_sel = ADD_LR;
            end
            ST_MID_BASE: begin
                w_add_a = DP_W'(w_sum_ll);
                w_add_b = DP_W'(w_sum_rr);
            end
            ST_MID: begin
                w_add_a = r_rem;
                w_add_b = w_lr2;
            end
            ST_SIDE: begin
                w_add_a   = r_rem;
                w_add_b   = w_lr2;
                w_add_sub = 1'b1;
            end
            ST_MAG: begin
                w_add_b   = w_lr_ext;
                w_add_sub = w_lr_neg;
            end
            ST_MAG_SQ, ST_DEN: begin
                w_add_a = w_rem_dbl;
                w_add_b = r_mplr[SUM_SQ_W-1] ? r_div : '0;
            end
            ST_DIV: begin
                w_add_a   = w_rem_dbl;
                w_add_b   = r_div;
                w_add_sub = 1'b1;
            end
            ST_SQRT: begin
                w_add_a   = w_rem_quad;
                w_add_b   = w_trial;
                w_add_sub = 1'b1;
            end
            ST_WIDTH_CHK: begin
                w_add_a   = DP_W'(r_side);
                w_add_b   = DP_W'(r_mid) << WIDTH_SCALE_LOG2;
                w_add_sub = 1'b1;
            end
            ST_OUT: begin
                w_acc_ctrl.clear = w_out_free;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Control registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_stereo_mode <= 1'b1;
        end else begin
            r_state <= n_state;
            if (w_cfg_write && (paddr[2] == REG_IDX_STEREO_MODE)) begin
                r_stereo_mode <= pwdata[0];
            end
            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Datapath of the final computation. Every working register is loaded
    // before the state that reads it, so none needs a reset.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_last <= i_last_sample;
                end
            end
            ST_MID_BASE: begin
                r_rem <= w_add_y;
            end
            ST_MID: begin
                r_mid <= w_add_y[MS_W-1:0];
            end
            ST_SIDE: begin
                r_side <= w_add_y[MS_W-1:0];
                if (w_silent) begin
                    r_corr <= CORR_MAX;
                end
            end
            ST_MAG: begin
                // Magnitude of the cross sum becomes multiplicand and multiplier.
                r_div  <= w_add_y;
                r_mplr <= w_add_y[SUM_SQ_W-1:0];
                r_rem  <= '0;
                r_cnt  <= '0;
                r_neg  <= w_lr_neg;
            end
            ST_MAG_SQ: begin
                if (w_mul_last) begin
                    r_num  <= w_add_y;
                    r_div  <= DP_W'(w_sum_ll);
                    r_mplr <= w_sum_rr;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_rem  <= w_add_y;
                    r_mplr <= {r_mplr[SUM_SQ_W-2:0], 1'b0};
                    r_cnt  <= r_cnt + STEP_W'(1);
                end
            end
            ST_DEN: begin
                if (w_mul_last) begin
                    // Divide by twice the denominator so the first quotient bit
                    // (a correlation of exactly one) falls inside 31 steps.
                    r_div   <= {w_add_y[DP_W-2:0], 1'b0};
                    r_rem   <= r_num;
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_wpass <= 1'b0;
                end else begin
                    r_rem  <= w_add_y;
                    r_mplr <= {r_mplr[SUM_SQ_W-2:0], 1'b0};
                    r_cnt  <= r_cnt + STEP_W'(1);
                end
            end
            ST_DIV: begin
                r_quo <= {r_quo[QUO_W-2:0], w_add_c};
                if (w_div_last) begin
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_rem <= w_add_c ? w_add_y : w_rem_dbl;
                    r_cnt <= r_cnt + STEP_W'(1);
                end
            end
            ST_SQRT: begin
                r_rem  <= w_add_c ? w_add_y : w_rem_quad;
                r_root <= w_root_next;
                r_quo  <= {r_quo[QUO_W-3:0], 2'b00};
                r_cnt  <= r_cnt + STEP_W'(1);
                if (w_sqrt_last) begin
                    if (r_wpass) begin
                        r_width <= w_root_next;
                    end else begin
                        r_corr <= w_corr_val;
                    end
                end
            end
            ST_WIDTH_CHK: begin
                if (w_mid_zero) begin
                    r_width <= '0;
                end else if (w_add_c) begin
                    // Side at least 65536 times mid: the root saturates.
                    r_width <= WIDTH_MAX;
                end else begin
                    r_rem   <= DP_W'(r_side);
                    r_div   <= DP_W'(r_mid) << WIDTH_SCALE_LOG2;
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_wpass <= 1'b1;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_out_corr  <= r_corr;
                    r_out_width <= r_width;
                end
            end
            default: ;
        endcase
    end

    assign o_valid             = r_out_valid;
    assign o_phase_correlation = r_out_corr;
    assign o_stereo_width      = r_out_width;

endmodule

// ===== src/scwm_accum.sv =====
// Sample accumulator: one shared 16x16 multiplier feeding the square and cross sums.
`timescale 1ns / 1ps

module scwm_accum import scwm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_acc_ctrl                  i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_left,
    input  logic signed [SAMPLE_W-1:0] i_right,
    output logic [SUM_SQ_W-1:0]        o_sum_ll,
    output logic [SUM_SQ_W-1:0]        o_sum_rr,
    output logic signed [SUM_X_W-1:0]  o_sum_lr
);

    logic signed [SAMPLE_W-1:0] r_left;
    logic signed [SAMPLE_W-1:0] r_right;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_take;
    logic [CNT_W-1:0]           r_count;
    logic [SUM_SQ_W-1:0]        r_sum_ll;
    logic [SUM_SQ_W-1:0]        r_sum_rr;
    logic signed [SUM_X_W-1:0]  r_sum_lr;

    logic signed [SAMPLE_W-1:0] w_mul_a;
    logic signed [SAMPLE_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic                       w_below_cap;

    assign w_below_cap = (r_count < SAMPLE_CAP);

    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_LL: begin
                w_mul_a = r_left;
                w_mul_b = r_left;
            end
            MUL_RR: begin
                w_mul_a = r_right;
                w_mul_b = r_right;
            end
            MUL_LR: begin
                w_mul_a = r_left;
                w_mul_b = r_right;
            end
            default: begin
                w_mul_a = r_left;
                w_mul_b = r_left;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_ctrl.capture) begin
            r_left  <= i_left;
            r_right <= i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_take   <= 1'b0;
            r_count  <= '0;
            r_sum_ll <= '0;
            r_sum_rr <= '0;
            r_sum_lr <= '0;
        end else if (i_ctrl.clear) begin
            r_take   <= 1'b0;
            r_count  <= '0;
            r_sum_ll <= '0;
            r_sum_rr <= '0;
            r_sum_lr <= '0;
        end else begin
            if (i_ctrl.capture) begin
                r_take <= w_below_cap;
                if (w_below_cap) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (r_take) begin
                case (i_ctrl.add_sel)
                    ADD_LL:  r_sum_ll <= r_sum_ll + SUM_SQ_W'($unsigned(r_prod));
                    ADD_RR:  r_sum_rr <= r_sum_rr + SUM_SQ_W'($unsigned(r_prod));
                    ADD_LR:  r_sum_lr <= r_sum_lr + SUM_X_W'(r_prod);
                    default: ;
                endcase
            end
        end
    end

    assign o_sum_ll = r_sum_ll;
    assign o_sum_rr = r_sum_rr;
    assign o_sum_lr = r_sum_lr;

endmodule

// ===== verif/stereo_correlation_width_meter_tb.sv =====
// Self-checking testbench for the stereo correlation and width meter.
`timescale 1ns / 1ps

module stereo_correlation_width_meter_tb;
    import scwm_pkg::*;

    // The only configuration register, stereo_mode, sits at byte address 0.
    localparam logic [2:0] REG_STEREO_MODE = 3'd0;

    // Pairs past this count in one block are dropped by the meter.
    localparam logic [25:0] PAIR_CAP = 26'(1) << MAX_SAMPLES_LOG2;

    // The random part stops once this many pairs have gone in overall, and the receiver
    // and sender stop idling once the tail threshold is crossed.
    localparam int PAIR_GOAL        = 950;
    localparam int QUIET_TAIL_START = 830;

    // The slowest correct run is roughly 950 blocks of one pair each; the limit is several
    // times as long.
    localparam int CYCLE_LIMIT = 1_000_000;

    // One meter reading as the result channel carries it.
    typedef struct packed {
        logic signed [15:0] correlation;
        logic [15:0]        width;
    } t_reading;

    // Sample value styles for the random blocks.
    typedef enum int {
        STYLE_INDEPENDENT,
        STYLE_CORRELATED,
        STYLE_ANTI,
        STYLE_EXTREME,
        STYLE_ONE_SILENT,
        STYLE_QUIET
    } t_pair_style;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_left_sample = '0;
    logic signed [15:0] i_right_sample = '0;
    logic               i_last_sample = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_phase_correlation;
    logic [15:0]        o_stereo_width;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    stereo_correlation_width_meter uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_left_sample      (i_left_sample),
        .i_right_sample     (i_right_sample),
        .i_last_sample      (i_last_sample),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_phase_correlation(o_phase_correlation),
        .o_stereo_width     (o_stereo_width),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // Predicted meter state: the five energy sums, the pair count and the mode setting.
    logic [55:0]        energy_left;
    logic [55:0]        energy_right;
    logic signed [56:0] energy_cross;
    logic [57:0]        energy_mid;
    logic [57:0]        energy_side;
    logic [25:0]        block_pairs;
    logic               stereo_mode_copy;

    // Readings that the meter still owes us, oldest first.
    t_reading pending_readings[$];

    // Flags that let either side of the data path idle at random.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    int error_count     = 0;
    int pairs_sent      = 0;
    int blocks_sent     = 0;
    int mono_blocks     = 0;
    int readings_seen   = 0;
    int negative_seen   = 0;
    int saturated_seen  = 0;
    int cycle_count     = 0;
    int stall_burst     = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: a run that hangs anywhere ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d readings outstanding",
                     cycle_count, pending_readings.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int expected_v, input int got_v);
        $display("ERROR cycle %0d: %s expected %0d got %0d", cycle_count, what, expected_v, got_v);
        error_count++;
    endtask

    // Largest q in [0, ceiling] with q*q*den <= num, found by bisection.
    function automatic logic [31:0] root_of_ratio(input logic [191:0] num,
                                                  input logic [191:0] den,
                                                  input logic [31:0] ceiling);
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  trial;
        logic [191:0] scaled;
        lo = '0;
        hi = ceiling;
        while (lo < hi) begin
            trial = (lo + hi + 1) / 2;
            scaled = 192'(trial) * 192'(trial) * den;
            if (scaled <= num) begin
                lo = trial;
            end else begin
                hi = trial - 1;
            end
        end
        return lo;
    endfunction

    // Folds one accepted pair into the predicted sums. On a pair marked last, the exact
    // correlation and width are worked out, queued as the expected reading, and the
    // sums clear for the next block.
    task automatic predict_pair(input logic signed [15:0] left, input logic signed [15:0] right,
                                input logic last);
        logic signed [31:0] lv;
        logic signed [31:0] rv;
        logic signed [31:0] mv;
        logic signed [31:0] sv;
        logic signed [63:0] p_ll;
        logic signed [63:0] p_rr;
        logic signed [63:0] p_lr;
        logic signed [63:0] p_mid;
        logic signed [63:0] p_side;
        logic               neg;
        logic [56:0]        mag;
        logic [191:0]       den;
        logic [191:0]       num;
        logic [31:0]        q;
        t_reading           rd;
        lv = left;
        // In mono mode the right channel is a copy of the left one.
        if (stereo_mode_copy) begin
            rv = right;
        end else begin
            rv = left;
        end
        mv = lv + rv;
        sv = lv - rv;
        p_ll = lv * lv;
        p_rr = rv * rv;
        p_lr = lv * rv;
        p_mid = mv * mv;
        p_side = sv * sv;
        if (block_pairs < PAIR_CAP) begin
            energy_left  = energy_left + p_ll[55:0];
            energy_right = energy_right + p_rr[55:0];
            energy_cross = energy_cross + p_lr[56:0];
            energy_mid   = energy_mid + p_mid[57:0];
            energy_side  = energy_side + p_side[57:0];
            block_pairs  = block_pairs + 26'd1;
        end
        if (last) begin
            // A silent channel reads as full positive correlation.
            if (energy_left == 0 || energy_right == 0) begin
                rd.correlation = CORR_MAX;
            end else begin
                neg = energy_cross[56];
                mag = neg ? -energy_cross : energy_cross;
                den = 192'(energy_left) * 192'(energy_right);
                num = (192'(mag) * 192'(mag)) << 30;
                q = root_of_ratio(num, den, 32'd32768);
                if (neg) begin
                    rd.correlation = 16'(32'd65536 - q);
                end else if (q > 32'd32767) begin
                    rd.correlation = CORR_MAX;
                end else begin
                    rd.correlation = q[15:0];
                end
            end
            // Zero mid energy reads as zero width; otherwise Q8.8, saturating.
            if (energy_mid == 0) begin
                rd.width = '0;
            end else begin
                q = root_of_ratio(192'(energy_side) << 16, 192'(energy_mid), 32'(WIDTH_MAX));
                rd.width = q[15:0];
            end
            pending_readings.push_back(rd);
            blocks_sent++;
            if (!stereo_mode_copy) begin
                mono_blocks++;
            end
            energy_left  = '0;
            energy_right = '0;
            energy_cross = '0;
            energy_mid   = '0;
            energy_side  = '0;
            block_pairs  = '0;
        end
    endtask

    // Presents one sample pair and holds it until the meter takes the transaction. The
    // valid line is left high on return so back-to-back pairs need no gap.
    task automatic send_pair(input logic signed [15:0] left, input logic signed [15:0] right,
                             input logic last);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_left_sample  <= left;
        i_right_sample <= right;
        i_last_sample  <= last;
        do @(posedge i_clk); while (o_stall);
        pairs_sent++;
        predict_pair(left, right, last);
    endtask

    // Lowers valid and waits until every owed reading is in, plus a short settling pause.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write of stereo_mode: setup cycle, then access cycle until pready.
    task automatic write_stereo_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_STEREO_MODE;
        pwdata  <= {31'd0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        stereo_mode_copy = mode;
    endtask

    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return -16'sd1;
            3: return 16'sd1;
            default: return 16'sd0;
        endcase
    endfunction

    // Draws one pair in the given style; styles steer the correlation toward +1, -1,
    // the silent cases and the saturation corners as well as plain noise.
    task automatic draw_pair(input t_pair_style style, output logic signed [15:0] left,
                             output logic signed [15:0] right);
        int base;
        base = $signed(16'($urandom));
        case (style)
            STYLE_CORRELATED: begin
                left  = 16'(base);
                right = clip16(base + $urandom_range(0, 64) - 32);
            end
            STYLE_ANTI: begin
                left  = 16'(base);
                right = clip16(-base + $urandom_range(0, 64) - 32);
            end
            STYLE_EXTREME: begin
                left  = pick_extreme();
                right = pick_extreme();
            end
            STYLE_ONE_SILENT: begin
                if ($urandom_range(0, 1)) begin
                    left  = 16'(base);
                    right = '0;
                end else begin
                    left  = '0;
                    right = 16'(base);
                end
            end
            STYLE_QUIET: begin
                left  = clip16($urandom_range(0, 16) - 8);
                right = clip16($urandom_range(0, 16) - 8);
            end
            default: begin
                left  = 16'($urandom);
                right = 16'($urandom);
            end
        endcase
    endtask

    // Result side: checks each accepted reading against the oldest prediction and
    // stalls the meter in short random bursts while idling is allowed.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected reading, correlation", -1, o_phase_correlation);
            end else begin
                want = pending_readings.pop_front();
                readings_seen++;
                if (want.correlation < 0) begin
                    negative_seen++;
                end
                if (want.width == WIDTH_MAX) begin
                    saturated_seen++;
                end
                if (o_phase_correlation !== want.correlation) begin
                    report_mismatch("phase_correlation", want.correlation, o_phase_correlation);
                end
                if (o_stereo_width !== want.width) begin
                    report_mismatch("stereo_width", want.width, o_stereo_width);
                end
            end
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_burst != 0) begin
            i_stall     <= 1'b1;
            stall_burst <= stall_burst - 1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            i_stall     <= 1'b1;
            stall_burst <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Hand-picked blocks in stereo mode: both channels silent, one channel silent,
    // full and inverted correlation, zero mid energy, width saturation and the sample
    // extremes in one block.
    task automatic test_stereo_corners();
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sh7FFF, 1'b1);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sd12345, 16'sd12345, 1'b1);
        send_pair(16'sh7FFF, -16'sd32767, 1'b1);
        send_pair(16'sh7FFF, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b0);
        send_pair(-16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd1, -16'sd1, 1'b1);
        send_pair(16'sh8000, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sh8000, 1'b1);
        // The sender holds off here until every reading so far is back.
        wait_drained();
    endtask

    // Mono mode: the right input must be ignored, so width is always zero.
    task automatic test_mono_mode();
        write_stereo_mode(1'b0);
        send_pair(16'sh7FFF, -16'sd5, 1'b0);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sd0, 16'sd123, 1'b1);
        send_pair(-16'sd1, -16'sd1, 1'b1);
        wait_drained();
        write_stereo_mode(1'b1);
    endtask

    // Bulk of the run: blocks of random length and style, with the mode changed and
    // the pipeline drained now and then between blocks. Most blocks are short so that
    // many readings come back; a few run long.
    task automatic test_random_blocks();
        int          len;
        int          n;
        int          pick;
        t_pair_style style;
        logic signed [15:0] left;
        logic signed [15:0] right;
        while (pairs_sent < PAIR_GOAL) begin
            if (pairs_sent >= QUIET_TAIL_START) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                len = $urandom_range(1, 8);
            end else if (pick < 19) begin
                len = $urandom_range(9, 40);
            end else begin
                len = $urandom_range(60, 150);
            end
            // The last block is cut short so the run ends right at the pair goal.
            if (len > PAIR_GOAL - pairs_sent) begin
                len = PAIR_GOAL - pairs_sent;
            end
            style = t_pair_style'($urandom_range(0, 5));
            for (n = 0; n < len; n++) begin
                draw_pair(style, left, right);
                send_pair(left, right, n == len - 1);
            end
            case ($urandom_range(0, 11))
                0: begin
                    wait_drained();
                    write_stereo_mode(1'($urandom_range(0, 1)));
                end
                1: wait_drained();
                default: ;
            endcase
        end
    endtask

    initial begin
        energy_left      = '0;
        energy_right     = '0;
        energy_cross     = '0;
        energy_mid       = '0;
        energy_side      = '0;
        block_pairs      = '0;
        stereo_mode_copy = 1'b1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stereo_corners();
        test_mono_mode();
        test_random_blocks();

        // Everything is sent: wait for the last readings and a margin for stray output.
        wait_drained();
        repeat (250) @(posedge i_clk);
        while (pending_readings.size() != 0) begin
            void'(pending_readings.pop_front());
            report_mismatch("reading never arrived, left over", 1, 0);
        end

        $display("Run covered %0d sample pairs in %0d blocks (%0d mono) and %0d readings.",
                 pairs_sent, blocks_sent, mono_blocks, readings_seen);
        $display("Readings with negative correlation: %0d, with saturated width: %0d.",
                 negative_seen, saturated_seen);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== stereo_correlation_width_meter.f =====
src/scwm_pkg.sv
src/scwm_accum.sv
src/stereo_correlation_width_meter.sv
verif/stereo_correlation_width_meter_tb.sv
